FILE: sv/pxs_pkg.sv
// Shared types and constants for the XOR selection read block.
// Used by pxs_front, pxs_queue, pxs_back and pir_xor_select_read; no dependencies.
package pxs_pkg;

    localparam int CNT_W  = 11;   // element count register
    localparam int NWD_W  = 4;    // words per element register
    localparam int OFF_W  = 10;   // rotate offset register
    localparam int SLOT_W = 7;    // selection byte index
    localparam int ELEM_W = 10;   // element index
    localparam int WIDX_W = 3;    // word index
    localparam int DATA_W = 64;   // data word

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_ELEMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_OFFSET     = 2'd2;

    // Input command codes.
    localparam logic CMD_LOAD_SELECT = 1'b0;
    localparam logic CMD_DATA_WORD   = 1'b1;

    // Effective configuration, already saturated where the registers allow.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [NWD_W-1:0] nwords;
        logic [OFF_W-1:0] offset;
    } t_cfg;

    // One classified element word handed from the front to the back.
    typedef struct packed {
        logic [WIDX_W-1:0] word_idx;
        logic [DATA_W-1:0] data;
        logic              hit;
        logic              final_word;
    } t_entry;

endpackage

FILE: sv/pxs_front.sv
// Front part: stores selection bytes and classifies element words.
// Holds the selection byte memory; depends on pxs_pkg.
module pxs_front #(
    parameter int SEL_DEPTH = 128,
    parameter int QDEPTH    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pxs_pkg::t_cfg            i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_command,
    input  logic [pxs_pkg::SLOT_W-1:0] i_slot,
    input  logic [7:0]               i_sel_byte,
    input  logic [pxs_pkg::ELEM_W-1:0] i_elem,
    input  logic [pxs_pkg::WIDX_W-1:0] i_word_idx,
    input  logic [pxs_pkg::DATA_W-1:0] i_data,
    input  logic                     i_final,
    input  logic [$clog2(QDEPTH+1)-1:0] i_q_count,
    output logic                     o_push,
    output pxs_pkg::t_entry          o_entry
);
    import pxs_pkg::*;

    localparam int MA = (SEL_DEPTH > 1) ? $clog2(SEL_DEPTH) : 1;

    logic [7:0] r_sel_mem [SEL_DEPTH];
    logic [7:0] r_sel_q;

    logic                r_s1_valid;
    logic                r_s1_inrange;
    logic [2:0]          r_s1_bitpos;
    logic [WIDX_W-1:0]   r_s1_word_idx;
    logic [DATA_W-1:0]   r_s1_data;
    logic                r_s1_final;

    logic              accept;
    logic              do_write;
    logic              do_read;
    logic [OFF_W-1:0]  off_eff;
    logic [CNT_W-1:0]  sum;
    logic [CNT_W-1:0]  bit_idx;
    logic              inrange;
    logic              hit;

    // Room is kept for the word in flight in stage one as well as a new one.
    assign o_ready = (32'(i_q_count) + 32'(r_s1_valid)) < QDEPTH;
    assign accept  = i_valid && o_ready;

    assign do_write = accept && (i_command == CMD_LOAD_SELECT) && (32'(i_slot) < SEL_DEPTH);
    assign do_read  = accept && (i_command == CMD_DATA_WORD);

    always_comb begin
        off_eff = ({1'b0, i_cfg.offset} >= i_cfg.count) ? '0 : i_cfg.offset;
        sum     = CNT_W'(i_elem) + CNT_W'(off_eff);
        bit_idx = (sum >= i_cfg.count) ? sum - i_cfg.count : sum;
        inrange = (CNT_W'(i_elem) < i_cfg.count) && (NWD_W'(i_word_idx) < i_cfg.nwords);
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_sel_mem[MA'(i_slot)] <= i_sel_byte;
        end
        if (do_read) begin
            r_sel_q <= r_sel_mem[MA'(bit_idx >> 3)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= do_read;
        end
        if (do_read) begin
            r_s1_inrange  <= inrange;
            r_s1_bitpos   <= bit_idx[2:0];
            r_s1_word_idx <= i_word_idx;
            r_s1_data     <= i_data;
            r_s1_final    <= i_final;
        end
    end

    assign hit    = r_s1_inrange && r_sel_q[r_s1_bitpos];
    // Words that change nothing are dropped unless they close the scan.
    assign o_push = r_s1_valid && (hit || r_s1_final);

    always_comb begin
        o_entry.word_idx   = r_s1_word_idx;
        o_entry.data       = r_s1_data;
        o_entry.hit        = hit;
        o_entry.final_word = r_s1_final;
    end

endmodule

FILE: sv/pxs_queue.sv
// Short queue between the front and the back parts.
// Register based; depends on pxs_pkg.
module pxs_queue #(
    parameter int DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  pxs_pkg::t_entry             i_entry,
    input  logic                        i_pop,
    output logic                        o_valid,
    output pxs_pkg::t_entry             o_entry,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);
    import pxs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (32'(r_count) < DEPTH || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");
`endif

endmodule

FILE: sv/pxs_back.sv
// Back part: XOR accumulator and result drain with its output register.
// Depends on pxs_pkg.
module pxs_back #(
    parameter int ACC_N = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pxs_pkg::t_cfg             i_cfg,
    input  logic                      i_q_valid,
    input  pxs_pkg::t_entry           i_q_entry,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [pxs_pkg::WIDX_W-1:0] o_word_idx,
    output logic [pxs_pkg::DATA_W-1:0] o_word,
    output logic                      o_last
);
    import pxs_pkg::*;

    localparam int AW = (ACC_N > 1) ? $clog2(ACC_N) : 1;

    logic [DATA_W-1:0] r_acc [ACC_N];
    logic              r_drain;
    logic [NWD_W-1:0]  r_k;
    logic              r_o_valid;
    logic [WIDX_W-1:0] r_o_idx;
    logic [DATA_W-1:0] r_o_word;
    logic              r_o_last;

    logic              out_free;
    logic              step;
    logic              k_stored;
    logic              k_last;
    logic [AW-1:0]     rd_idx;
    logic [DATA_W-1:0] acc_rd;

    assign out_free = !r_o_valid || i_ready;
    assign o_pop    = i_q_valid && !r_drain;
    assign step     = r_drain && out_free;
    assign k_stored = 32'(r_k) < ACC_N;
    assign k_last   = (r_k + 1'b1) == i_cfg.nwords;

    // One read port, shared by the drain and by accumulation.
    assign rd_idx = r_drain ? AW'(r_k) : AW'(i_q_entry.word_idx);
    assign acc_rd = r_acc[rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACC_N; i++) begin
                r_acc[i] <= '0;
            end
            r_drain   <= 1'b0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop && i_q_entry.hit) begin
                r_acc[rd_idx] <= acc_rd ^ i_q_entry.data;
            end else if (step && k_last) begin
                // The read-out ends by clearing every position, including any
                // left over from a larger words-per-element setting.
                for (int i = 0; i < ACC_N; i++) begin
                    r_acc[i] <= '0;
                end
            end else if (step && k_stored) begin
                r_acc[rd_idx] <= '0;
            end
            if (o_pop && i_q_entry.final_word) begin
                r_drain <= 1'b1;
                r_k     <= '0;
            end else if (step) begin
                r_k <= r_k + 1'b1;
                if (k_last) begin
                    r_drain <= 1'b0;
                end
            end
            if (step) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (step) begin
            r_o_idx  <= r_k[WIDX_W-1:0];
            r_o_word <= k_stored ? acc_rd : '0;
            r_o_last <= k_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_word_idx = r_o_idx;
    assign o_word     = r_o_word;
    assign o_last     = r_o_last;

`ifndef SYNTH
    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> r_k < i_cfg.nwords)
        else $error("drain index past words per element");
    a_drain_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_entry.final_word) |=> (r_drain && r_k == '0))
        else $error("drain did not start at word zero");
`endif

endmodule

FILE: sv/pir_xor_select_read.sv
// Throughput: one item per cycle while the queue has room; a final word makes the
// back part emit words_per_element results, one per cycle while the output is taken,
// while the queue absorbs up to four words. From an accepted final word, the first result
// passes the selection memory read, the queue and the drain into the output register.
// Reset: synchronous, active low; clears control state and the accumulator, returns the
// configuration registers to their defaults; selection bytes stay undefined until written.
module pir_xor_select_read #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int WORDS        = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [pxs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pxs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [6:0] select_byte_index, [14:7] select_byte, [24:15] element_index,
    // [27:25] word_index, [91:28] data_word, [95:92] zero
    input  logic [95:0]                        s_axis_tdata,
    // [0] command
    input  logic                               s_axis_tuser,
    // final_word
    input  logic                               s_axis_tlast,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] out_word_index, [66:3] out_word, [71:67] zero
    output logic [71:0]                        m_axis_tdata,
    // out_last
    output logic                               m_axis_tlast
);
    import pxs_pkg::*;

    // The selection index field reaches at most 128 bytes.
    localparam int SEL_BYTES = (MAX_ELEMENTS + 7) / 8;
    localparam int SEL_DEPTH = (SEL_BYTES > 128) ? 128 : SEL_BYTES;
    // Only word positions the word index field can name are ever nonzero.
    localparam int ACC_N     = (WORDS > 8) ? 8 : WORDS;
    localparam int QDEPTH    = 4;
    localparam int CNT_MAXI  = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
    localparam int NWD_MAXI  = (WORDS > 15) ? 15 : WORDS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CNT_MAXI);
    localparam logic [NWD_W-1:0] NWD_MAX = NWD_W'(NWD_MAXI);
    localparam logic [CNT_W-1:0] CNT_RST = CNT_W'((CNT_MAXI < 1024) ? CNT_MAXI : 1024);
    localparam logic [NWD_W-1:0] NWD_RST = NWD_W'((NWD_MAXI < 8) ? NWD_MAXI : 8);

    // Count and words-per-element registers hold the effective (saturated) values; the offset is kept as written.
    t_cfg             r_cfg;
    logic [CNT_W-1:0] cfg_cnt;
    logic [NWD_W-1:0] cfg_nwd;

    assign cfg_cnt = i_cfg_data[CNT_W-1:0];
    assign cfg_nwd = i_cfg_data[NWD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count  <= CNT_RST;
            r_cfg.nwords <= NWD_RST;
            r_cfg.offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ELEMENT_COUNT: begin
                    r_cfg.count <= (cfg_cnt == '0) ? CNT_W'(1) :
                                   (cfg_cnt > CNT_MAX) ? CNT_MAX : cfg_cnt;
                end
                REG_WORDS_PER_ELEMENT: begin
                    r_cfg.nwords <= (cfg_nwd == '0) ? NWD_W'(1) :
                                    (cfg_nwd > NWD_MAX) ? NWD_MAX : cfg_nwd;
                end
                REG_ROTATE_OFFSET: begin
                    r_cfg.offset <= i_cfg_data[OFF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic                        push;
    t_entry                      push_entry;
    logic                        q_valid;
    t_entry                      q_entry;
    logic [$clog2(QDEPTH+1)-1:0] q_count;
    logic                        pop;
    logic [WIDX_W-1:0]           out_idx;
    logic [DATA_W-1:0]           out_word;

    // The front reads the selection bit for each word and passes only words that
    // change the accumulator, plus the word that closes the scan.
    pxs_front #(
        .SEL_DEPTH (SEL_DEPTH),
        .QDEPTH    (QDEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_command  (s_axis_tuser),
        .i_slot     (s_axis_tdata[6:0]),
        .i_sel_byte (s_axis_tdata[14:7]),
        .i_elem     (s_axis_tdata[24:15]),
        .i_word_idx (s_axis_tdata[27:25]),
        .i_data     (s_axis_tdata[91:28]),
        .i_final    (s_axis_tlast),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    pxs_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    // The back XORs words in and, after the closing word, drains and clears
    // the accumulator; it takes no queue entry while draining.
    pxs_back #(
        .ACC_N (ACC_N)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_word_idx (out_idx),
        .o_word     (out_word),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, out_word, out_idx};

endmodule
